[rtl/fbpm_pkg.sv]
// ----------------------------------------------------------------------------
// fbpm_pkg
// Shared types, codes and helpers for the frame buffer pool manager.
// ----------------------------------------------------------------------------
`default_nettype none

package fbpm_pkg;

  localparam int unsigned MaxFrames = 8;
  localparam int unsigned FrameW    = $clog2(MaxFrames);
  localparam int unsigned CntW      = FrameW + 1;
  localparam int unsigned PoolW     = 4;
  localparam int unsigned KindW     = 3;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned OutDataW  = 24;
  localparam int unsigned PoolRst   = 8;

  typedef logic [FrameW-1:0] frame_t;
  typedef logic [CntW-1:0]   cnt_t;
  typedef logic [PoolW-1:0]  pool_t;

  typedef enum logic [KindW-1:0] {
    KIND_TAKE_WRITE  = 3'd0,
    KIND_SUBMIT      = 3'd1,
    KIND_TAKE_READ   = 3'd2,
    KIND_RELEASE     = 3'd3,
    KIND_RECYCLE     = 3'd4,
    KIND_LINK        = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_NONE     = 2'd1,
    STS_WRONG    = 2'd2,
    STS_TOO_LONG = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FS_FREE    = 2'd0,
    FS_WRITING = 2'd1,
    FS_READY   = 2'd2,
    FS_READING = 2'd3
  } fstate_e;

  typedef enum logic {
    REG_POOL_SIZE = 1'b0,
    REG_NOTIFY_EN = 1'b1
  } cfg_reg_e;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXEC   = 6'b000010,
    S_CHECK  = 6'b000100,
    S_RETURN = 6'b001000,
    S_LINK   = 6'b010000,
    S_DONE   = 6'b100000
  } fsm_e;

  // Effective pool size: zero acts as one, oversize clamps to the pool depth.
  function automatic cnt_t pool_eff(input pool_t sz);
    cnt_t res;
    if (sz == '0) begin
      res = cnt_t'(1);
    end else if (int'(sz) > MaxFrames) begin
      res = cnt_t'(MaxFrames);
    end else begin
      res = cnt_t'(sz);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/frame_buffer_pool_manager_top.sv]
// ----------------------------------------------------------------------------
// frame_buffer_pool_manager_top
// Frame buffer pool manager: free/ready queues with linked-chain recycling.
//
// One operation per slave transaction (kind on tuser, frame indices on tdata);
// one result per operation on the master side (granted frame, status, notify,
// ready-empty flag and the free/ready/in-flight counts after the operation).
// The block takes one operation at a time: s_axis_tready is high only while
// the sequencer is idle. Take, submit and unknown kinds finish in the execute
// state: the result is registered, or held in the done state while the master side stalls.
// Release and recycle walk the chain through the link table one frame per
// cycle: the check state vets the whole chain, then the return state gives it
// back to the free queue (a rejected walk stops early). Link walks to the
// chain end in the link state. The link-table walk is the single shared step
// behind all three kinds.
// The result register frees the sequencer; a new operation is taken while a
// result waits, and the sequencer holds the next result until the master
// side drains. Reset loads 8 frames into the free queue, notify disabled.
// A pool_size write rebuilds the pool.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_buffer_pool_manager_top
  import fbpm_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // config write port
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_index_i,
  input  wire logic [PoolW-1:0]    cfg_data_i,
  // operation stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // [2:0] frame_index, [5:3] other_index
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // [2:0] kind
  input  wire logic [KindW-1:0]    s_axis_tuser,
  // result stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [2:0] granted_frame, [4:3] status, [5] notify, [6] ready_empty,
  // [10:7] free_count, [14:11] ready_count, [18:15] in_flight
  output logic [OutDataW-1:0]      m_axis_tdata
);

  // control state
  fsm_e     state_q, state_d;
  pool_t    pool_size_q;
  logic     notify_en_q;
  frame_t   fhead_q, fhead_d;
  cnt_t     fcnt_q, fcnt_d;
  frame_t   rhead_q, rhead_d;
  cnt_t     rcnt_q, rcnt_d;
  logic     rempty_q, rempty_d;
  logic     m_valid_q;

  frame_t   free_fifo_q [MaxFrames];
  frame_t   ready_fifo_q [MaxFrames];
  fstate_e  fstate_q [MaxFrames];
  logic     lvalid_q [MaxFrames];
  frame_t   lto_q [MaxFrames];

  // operation and walk registers
  kind_e    kind_q;
  frame_t   f_q, o_q;
  frame_t   cur_q, cur_d;
  cnt_t     i_q, i_d;
  cnt_t     len_q, len_d;
  frame_t   hold_granted_q, hold_granted_d;
  status_e  hold_status_q, hold_status_d;
  logic     hold_notify_q, hold_notify_d;
  logic [OutDataW-1:0] m_data_q;

  // combinational
  cnt_t     n_eff;
  cnt_t     i_inc;
  frame_t   rd_idx;
  fstate_e  st_rd;
  logic     lv_rd;
  frame_t   lto_rd;
  logic     st_we;
  frame_t   st_waddr;
  fstate_e  st_wdata;
  logic     lk_we;
  frame_t   lk_waddr;
  logic     lk_wvalid;
  frame_t   lk_wto;
  logic     ff_we;
  frame_t   ff_wdata;
  logic     rf_we;
  logic     fin;
  logic     out_free;
  logic     out_load;
  frame_t   res_granted;
  status_e  res_status;
  logic     res_notify;
  cnt_t     in_flight;
  logic     in_acc;
  logic     rebuild;
  cnt_t     n_new;

  assign n_eff         = pool_eff(pool_size_q);
  assign i_inc         = i_q + cnt_t'(1);
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign rebuild       = cfg_we_i && (cfg_index_i == REG_POOL_SIZE);
  assign n_new         = pool_eff(cfg_data_i);

  // single read port into the frame tables
  assign rd_idx = (state_q == S_EXEC) ? f_q : cur_q;
  assign st_rd  = fstate_q[rd_idx];
  assign lv_rd  = lvalid_q[rd_idx];
  assign lto_rd = lto_q[rd_idx];

  always_comb begin
    state_d        = state_q;
    fhead_d        = fhead_q;
    fcnt_d         = fcnt_q;
    rhead_d        = rhead_q;
    rcnt_d         = rcnt_q;
    rempty_d       = rempty_q;
    cur_d          = cur_q;
    i_d            = i_q;
    len_d          = len_q;
    hold_granted_d = hold_granted_q;
    hold_status_d  = hold_status_q;
    hold_notify_d  = hold_notify_q;
    st_we          = 1'b0;
    st_waddr       = rd_idx;
    st_wdata       = FS_FREE;
    lk_we          = 1'b0;
    lk_waddr       = cur_q;
    lk_wvalid      = 1'b0;
    lk_wto         = '0;
    ff_we          = 1'b0;
    ff_wdata       = cur_q;
    rf_we          = 1'b0;
    fin            = 1'b0;
    out_load       = 1'b0;
    res_granted    = '0;
    res_status     = STS_OK;
    res_notify     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cur_d = f_q;
        i_d   = '0;
        unique case (kind_q)
          KIND_TAKE_WRITE: begin
            fin = 1'b1;
            if (fcnt_q == '0) begin
              res_status = STS_NONE;
            end else begin
              res_granted = free_fifo_q[fhead_q];
              fhead_d     = fhead_q + frame_t'(1);
              fcnt_d      = fcnt_q - cnt_t'(1);
              st_we       = 1'b1;
              st_waddr    = res_granted;
              st_wdata    = FS_WRITING;
            end
          end
          KIND_SUBMIT: begin
            fin = 1'b1;
            if (cnt_t'(f_q) >= n_eff || st_rd != FS_WRITING ||
                rcnt_q >= cnt_t'(MaxFrames)) begin
              res_status = STS_WRONG;
            end else begin
              st_we      = 1'b1;
              st_waddr   = f_q;
              st_wdata   = FS_READY;
              rf_we      = 1'b1;
              rcnt_d     = rcnt_q + cnt_t'(1);
              rempty_d   = 1'b0;
              res_notify = notify_en_q;
            end
          end
          KIND_TAKE_READ: begin
            fin = 1'b1;
            if (rcnt_q == '0) begin
              res_status = STS_NONE;
            end else begin
              res_granted = ready_fifo_q[rhead_q];
              rhead_d     = rhead_q + frame_t'(1);
              rcnt_d      = rcnt_q - cnt_t'(1);
              rempty_d    = (rcnt_q == cnt_t'(1));
              st_we       = 1'b1;
              st_waddr    = res_granted;
              st_wdata    = FS_READING;
            end
          end
          KIND_RELEASE: begin
            if (cnt_t'(f_q) >= n_eff || st_rd != FS_READING) begin
              fin        = 1'b1;
              res_status = STS_WRONG;
            end else begin
              state_d = S_CHECK;
            end
          end
          KIND_RECYCLE: begin
            if (cnt_t'(f_q) >= n_eff) begin
              fin        = 1'b1;
              res_status = STS_WRONG;
            end else begin
              state_d = S_CHECK;
            end
          end
          KIND_LINK: begin
            if (cnt_t'(f_q) >= n_eff || cnt_t'(o_q) >= n_eff) begin
              fin        = 1'b1;
              res_status = STS_WRONG;
            end else begin
              state_d = S_LINK;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      S_CHECK: begin
        // whole chain must be in flight and end within the pool size
        if (st_rd != FS_WRITING && st_rd != FS_READING) begin
          fin        = 1'b1;
          res_status = STS_WRONG;
        end else if (!lv_rd) begin
          len_d   = i_inc;
          cur_d   = f_q;
          i_d     = '0;
          state_d = S_RETURN;
        end else begin
          cur_d = lto_rd;
          i_d   = i_inc;
          if (i_inc == n_eff) begin
            fin        = 1'b1;
            res_status = STS_TOO_LONG;
          end
        end
      end
      S_RETURN: begin
        st_we     = 1'b1;
        st_waddr  = cur_q;
        st_wdata  = FS_FREE;
        lk_we     = 1'b1;
        lk_waddr  = cur_q;
        if (fcnt_q < cnt_t'(MaxFrames)) begin
          ff_we  = 1'b1;
          fcnt_d = fcnt_q + cnt_t'(1);
        end
        cur_d = lto_rd;
        i_d   = i_inc;
        if (i_inc == len_q) begin
          fin = 1'b1;
        end
      end
      S_LINK: begin
        if (!lv_rd) begin
          lk_we     = 1'b1;
          lk_waddr  = cur_q;
          lk_wvalid = 1'b1;
          lk_wto    = o_q;
          fin       = 1'b1;
        end else begin
          cur_d = lto_rd;
          i_d   = i_inc;
          if (i_inc == n_eff) begin
            fin        = 1'b1;
            res_status = STS_TOO_LONG;
          end
        end
      end
      S_DONE: begin
        fin         = 1'b1;
        res_granted = hold_granted_q;
        res_status  = hold_status_q;
        res_notify  = hold_notify_q;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      if (out_free) begin
        out_load = 1'b1;
        state_d  = S_IDLE;
      end else begin
        state_d        = S_DONE;
        hold_granted_d = res_granted;
        hold_status_d  = res_status;
        hold_notify_d  = res_notify;
      end
    end
  end

  assign in_flight = n_eff - fcnt_d - rcnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pool_size_q <= pool_t'(PoolRst);
      notify_en_q <= 1'b0;
      fhead_q     <= '0;
      fcnt_q      <= pool_eff(pool_t'(PoolRst));
      rhead_q     <= '0;
      rcnt_q      <= '0;
      rempty_q    <= 1'b1;
      m_valid_q   <= 1'b0;
      for (int k = 0; k < MaxFrames; k++) begin
        free_fifo_q[k] <= frame_t'(k);
        fstate_q[k]    <= FS_FREE;
        lvalid_q[k]    <= 1'b0;
        lto_q[k]       <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_we_i && cfg_index_i == REG_NOTIFY_EN) begin
        notify_en_q <= cfg_data_i[0];
      end
      if (rebuild) begin
        pool_size_q <= cfg_data_i;
        fhead_q     <= '0;
        fcnt_q      <= n_new;
        rhead_q     <= '0;
        rcnt_q      <= '0;
        rempty_q    <= 1'b1;
        for (int k = 0; k < MaxFrames; k++) begin
          free_fifo_q[k] <= frame_t'(k);
          fstate_q[k]    <= FS_FREE;
          lvalid_q[k]    <= 1'b0;
          lto_q[k]       <= '0;
        end
      end else begin
        fhead_q  <= fhead_d;
        fcnt_q   <= fcnt_d;
        rhead_q  <= rhead_d;
        rcnt_q   <= rcnt_d;
        rempty_q <= rempty_d;
        if (st_we) begin
          fstate_q[st_waddr] <= st_wdata;
        end
        if (lk_we) begin
          lvalid_q[lk_waddr] <= lk_wvalid;
          lto_q[lk_waddr]    <= lk_wto;
        end
        if (ff_we) begin
          free_fifo_q[fhead_q + fcnt_q[FrameW-1:0]] <= ff_wdata;
        end
      end
    end
  end

  // payload, ready queue, walk and result registers (no reset)
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= kind_e'(s_axis_tuser);
      f_q    <= s_axis_tdata[FrameW-1:0];
      o_q    <= s_axis_tdata[2*FrameW-1:FrameW];
    end
    if (rf_we) begin
      ready_fifo_q[rhead_q + rcnt_q[FrameW-1:0]] <= f_q;
    end
    cur_d_reg: begin
      cur_q <= cur_d;
    end
    i_q            <= i_d;
    len_q          <= len_d;
    hold_granted_q <= hold_granted_d;
    hold_status_q  <= hold_status_d;
    hold_notify_q  <= hold_notify_d;
    if (out_load) begin
      m_data_q <= {5'b0, in_flight, rcnt_d, fcnt_d, rempty_d, res_notify,
                   res_status, res_granted};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef SYNTH
  a_rempty_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rempty_q == (rcnt_q == '0))
    else $error("ready-empty flag disagrees with ready count");

  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, fcnt_q} + {1'b0, rcnt_q}) <= (CntW+1)'(MaxFrames))
    else $error("free plus ready count exceeds pool depth");

  a_return_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RETURN |-> i_q < len_q)
    else $error("chain return ran past chain length");

  a_walk_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK || state_q == S_LINK) |-> i_q < n_eff)
    else $error("chain walk ran past pool size");

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_EXEC)
    else $error("accepted transaction not executed");
`endif

endmodule

`default_nettype wire

[tb/fbpm_pool_checker.sv]
// ----------------------------------------------------------------------------
// fbpm_pool_checker
// Watches the config port and both streams of the frame buffer pool manager.
// Keeps its own copy of the free/ready queues, frame states and chain links,
// predicts the report of every accepted operation and compares each accepted
// result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbpm_pool_checker
  import fbpm_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_index_i,
  input  wire logic [PoolW-1:0]    cfg_data_i,
  input  wire logic                s_tvalid_i,
  input  wire logic                s_tready_i,
  input  wire logic [InDataW-1:0]  s_tdata_i,
  input  wire logic [KindW-1:0]    s_tuser_i,
  input  wire logic                m_tvalid_i,
  input  wire logic                m_tready_i,
  input  wire logic [OutDataW-1:0] m_tdata_i,
  output int                       err_count_o,
  output int                       pending_o
);

  typedef struct packed {
    frame_t     granted;
    status_e    status;
    logic       notify;
    logic       rdy_empty;
    logic [3:0] free_cnt;
    logic [3:0] ready_cnt;
    logic [3:0] in_flight;
  } pool_report_t;

  frame_t       free_slots  [MaxFrames];
  frame_t       ready_slots [MaxFrames];
  fstate_e      fr_state    [MaxFrames];
  logic         linked      [MaxFrames];
  frame_t       link_next   [MaxFrames];
  frame_t       free_rd;
  cnt_t         free_num;
  frame_t       ready_rd;
  cnt_t         ready_num;
  logic         rdy_empty;
  pool_t        pool_reg;
  logic         notify_on;
  int           errors;
  pool_report_t pool_reports_q[$];

  function automatic int unsigned active_frames(input pool_t sz);
    if (sz == '0) return 1;
    return (sz > MaxFrames) ? MaxFrames : int'(sz);
  endfunction

  function automatic void rebuild_pool();
    int unsigned n;
    n = active_frames(pool_reg);
    for (int unsigned i = 0; i < MaxFrames; i++) begin
      free_slots[i]  = (i < n) ? frame_t'(i) : '0;
      ready_slots[i] = '0;
      fr_state[i]    = FS_FREE;
      linked[i]      = 1'b0;
      link_next[i]   = '0;
    end
    free_rd   = '0;
    free_num  = cnt_t'(n);
    ready_rd  = '0;
    ready_num = '0;
    rdy_empty = 1'b1;
  endfunction

  // Whole chain is vetted first; only a clean walk frees anything.
  function automatic status_e return_chain(input frame_t head);
    int unsigned n;
    int unsigned len;
    frame_t      cur;
    bit          ended;
    status_e     st;
    n     = active_frames(pool_reg);
    cur   = head;
    len   = 0;
    ended = 1'b0;
    st    = STS_OK;
    for (int unsigned i = 0; i < n && !ended && st == STS_OK; i++) begin
      if (fr_state[cur] != FS_WRITING && fr_state[cur] != FS_READING) begin
        st = STS_WRONG;
      end else if (!linked[cur]) begin
        len   = i + 1;
        ended = 1'b1;
      end else begin
        cur = link_next[cur];
      end
    end
    if (st == STS_OK && !ended) st = STS_TOO_LONG;
    if (st == STS_OK) begin
      cur = head;
      for (int unsigned i = 0; i < len; i++) begin
        frame_t nxt;
        nxt           = link_next[cur];
        fr_state[cur] = FS_FREE;
        linked[cur]   = 1'b0;
        link_next[cur] = '0;
        if (free_num < MaxFrames) begin
          free_slots[free_rd + frame_t'(free_num)] = cur;
          free_num++;
        end
        cur = nxt;
      end
    end
    return st;
  endfunction

  function automatic pool_report_t predict_pool_op(input logic [KindW-1:0] kind,
                                                   input frame_t fi, input frame_t oi);
    pool_report_t rep;
    int unsigned  n;
    frame_t       cur;
    bit           placed;
    n          = active_frames(pool_reg);
    rep        = '0;
    rep.status = STS_OK;
    case (kind)
      KIND_TAKE_WRITE: begin
        if (free_num == 0) begin
          rep.status = STS_NONE;
        end else begin
          rep.granted = free_slots[free_rd];
          free_rd++;
          free_num--;
          fr_state[rep.granted] = FS_WRITING;
        end
      end
      KIND_SUBMIT: begin
        if (fi >= n || fr_state[fi] != FS_WRITING || ready_num >= MaxFrames) begin
          rep.status = STS_WRONG;
        end else begin
          fr_state[fi] = FS_READY;
          ready_slots[ready_rd + frame_t'(ready_num)] = fi;
          ready_num++;
          rdy_empty  = 1'b0;
          rep.notify = notify_on;
        end
      end
      KIND_TAKE_READ: begin
        if (ready_num == 0) begin
          rep.status = STS_NONE;
        end else begin
          rep.granted = ready_slots[ready_rd];
          ready_rd++;
          ready_num--;
          fr_state[rep.granted] = FS_READING;
          rdy_empty = (ready_num == 0);
        end
      end
      KIND_RELEASE: begin
        if (fi >= n || fr_state[fi] != FS_READING) rep.status = STS_WRONG;
        else rep.status = return_chain(fi);
      end
      KIND_RECYCLE: begin
        if (fi >= n) rep.status = STS_WRONG;
        else rep.status = return_chain(fi);
      end
      KIND_LINK: begin
        if (fi >= n || oi >= n) begin
          rep.status = STS_WRONG;
        end else begin
          cur    = fi;
          placed = 1'b0;
          for (int unsigned i = 0; i < n && !placed; i++) begin
            if (!linked[cur]) begin
              linked[cur]    = 1'b1;
              link_next[cur] = oi;
              placed         = 1'b1;
            end else begin
              cur = link_next[cur];
            end
          end
          if (!placed) rep.status = STS_TOO_LONG;
        end
      end
      default: ;
    endcase
    rep.rdy_empty = rdy_empty;
    rep.free_cnt  = free_num;
    rep.ready_cnt = ready_num;
    rep.in_flight = 4'(n - free_num - ready_num);
    return rep;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    pool_report_t want;
    pool_report_t pred;
    if (!rst_ni) begin
      pool_reg  = pool_t'(PoolRst);
      notify_on = 1'b0;
      errors    = 0;
      rebuild_pool();
      pool_reports_q.delete();
      err_count_o <= 0;
      pending_o   <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (pool_reports_q.size() == 0) begin
          $error("result transaction with nothing outstanding: %h", m_tdata_i);
          errors++;
        end else begin
          want = pool_reports_q[0];
          pool_reports_q.delete(0);
          check_field("granted_frame", int'(want.granted),   int'(m_tdata_i[2:0]));
          check_field("status",        int'(want.status),    int'(m_tdata_i[4:3]));
          check_field("notify",        int'(want.notify),    int'(m_tdata_i[5]));
          check_field("ready_empty",   int'(want.rdy_empty), int'(m_tdata_i[6]));
          check_field("free_count",    int'(want.free_cnt),  int'(m_tdata_i[10:7]));
          check_field("ready_count",   int'(want.ready_cnt), int'(m_tdata_i[14:11]));
          check_field("in_flight",     int'(want.in_flight), int'(m_tdata_i[18:15]));
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i == REG_POOL_SIZE) begin
          pool_reg = cfg_data_i;
          rebuild_pool();
        end else begin
          notify_on = cfg_data_i[0];
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        pred = predict_pool_op(s_tuser_i, s_tdata_i[2:0], s_tdata_i[5:3]);
        pool_reports_q = {pool_reports_q, pred};
      end
      err_count_o <= errors;
      pending_o   <= pool_reports_q.size();
    end
  end

endmodule

[tb/frame_buffer_pool_manager_top_tb.sv]
// ----------------------------------------------------------------------------
// frame_buffer_pool_manager_top_tb
// Drives operations into the pool manager: a directed pass over the corner
// cases, then random phases at many pool sizes with mostly well-formed
// take/submit/release/link traffic and random stalls on both streams. The
// checker beside the block does the prediction; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frame_buffer_pool_manager_top_tb;
  import fbpm_pkg::*;

  localparam logic [KindW-1:0] KindSpareA = 3'd6;
  localparam logic [KindW-1:0] KindSpareB = 3'd7;
  localparam int CycleLimit    = 1_000_000;
  localparam int ItemsPerPhase = 125;
  localparam int NumPhases     = 12;
  localparam int SettleCycles  = 20;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic                cfg_index;
  logic [PoolW-1:0]    cfg_data;
  logic                s_tvalid;
  wire                 s_tready;
  logic [InDataW-1:0]  s_tdata;
  logic [KindW-1:0]    s_tuser;
  wire                 m_tvalid;
  logic                m_tready = 1'b0;
  wire [OutDataW-1:0]  m_tdata;
  int                  err_count;
  int                  pending;

  int                  n_frames = MaxFrames;
  bit                  no_gap   = 1'b0;
  bit                  no_stall = 1'b0;
  int                  hold_cnt = 0;
  logic [KindW-1:0]    op_kinds[$];
  frame_t              writing_q[$];
  frame_t              reading_q[$];
  pool_t               phase_sizes[NumPhases];

  frame_buffer_pool_manager_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  fbpm_pool_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tuser_i   (s_tuser),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result-side backpressure: short stalls mostly, an occasional long one.
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (no_stall || !m_tready) begin
      m_tready <= 1'b1;
      hold_cnt <= $urandom_range(0, 12);
    end else begin
      m_tready <= 1'b0;
      hold_cnt <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 40);
    end
  end

  // Remember granted frames so that later operations can target them.
  always @(posedge clk) begin : grant_tracker
    logic [KindW-1:0] k;
    if (rst_n && m_tvalid && m_tready && op_kinds.size() != 0) begin
      k = op_kinds[0];
      op_kinds.delete(0);
      if (m_tdata[4:3] == STS_OK) begin
        if (k == KIND_TAKE_WRITE) writing_q = {writing_q, frame_t'(m_tdata[2:0])};
        if (k == KIND_TAKE_READ) reading_q = {reading_q, frame_t'(m_tdata[2:0])};
        if (writing_q.size() > MaxFrames) writing_q.delete(0);
        if (reading_q.size() > MaxFrames) reading_q.delete(0);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_gap) return 0;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic frame_t take_hint(ref frame_t q[$]);
    int     idx;
    frame_t fr;
    idx = $urandom_range(0, q.size() - 1);
    fr  = q[idx];
    q.delete(idx);
    return fr;
  endfunction

  task automatic send_op(input logic [KindW-1:0] kind, input frame_t fi, input frame_t oi);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {2'b00, oi, fi};
    do @(posedge clk); while (!s_tready);
    op_kinds = {op_kinds, kind};
  endtask

  task automatic drain_ops();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [PoolW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_POOL_SIZE) begin
      n_frames = (val == 0) ? 1 : ((val > MaxFrames) ? MaxFrames : int'(val));
      writing_q.delete();
      reading_q.delete();
    end
  endtask

  task automatic pick_op(output logic [KindW-1:0] k, output frame_t fi, output frame_t oi);
    int r;
    r  = $urandom_range(0, 99);
    fi = frame_t'($urandom_range(0, n_frames - 1));
    oi = frame_t'($urandom_range(0, n_frames - 1));
    if (r < 20) begin
      k = KIND_TAKE_WRITE;
    end else if (r < 40) begin
      k = KIND_SUBMIT;
      if (writing_q.size() != 0 && $urandom_range(0, 4) != 0) fi = take_hint(writing_q);
    end else if (r < 55) begin
      k = KIND_TAKE_READ;
    end else if (r < 70) begin
      k = KIND_RELEASE;
      if (reading_q.size() != 0 && $urandom_range(0, 4) != 0) fi = take_hint(reading_q);
    end else if (r < 80) begin
      k = KIND_RECYCLE;
      if (writing_q.size() != 0 && $urandom_range(0, 1) != 0) fi = take_hint(writing_q);
      else if (reading_q.size() != 0 && $urandom_range(0, 2) != 0) fi = take_hint(reading_q);
    end else if (r < 92) begin
      // chain a writing frame behind another in-use frame
      k = KIND_LINK;
      if (writing_q.size() != 0) oi = take_hint(writing_q);
      if (writing_q.size() != 0) fi = writing_q[$urandom_range(0, writing_q.size() - 1)];
      else if (reading_q.size() != 0) fi = reading_q[0];
    end else if (r < 96) begin
      k  = KindW'($urandom_range(0, 7));
      fi = frame_t'($urandom_range(0, 7));
      oi = frame_t'($urandom_range(0, 7));
    end else begin
      k = r[0] ? KindSpareA : KindSpareB;
    end
  endtask

  initial begin : stimulus
    logic [KindW-1:0] k;
    frame_t           fi;
    frame_t           oi;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_POOL_SIZE;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    phase_sizes = '{4'd1, 4'd2, 4'd3, 4'd0, 4'd4, 4'd8, 4'd15, 4'd5, 4'd2, 4'd6, 4'd7, 4'd11};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pass at the reset pool size of eight.
    for (int i = 0; i <= MaxFrames; i++) send_op(KIND_TAKE_WRITE, 3'd7, 3'd7);
    send_op(KIND_TAKE_READ, 3'd0, 3'd0);
    send_op(KIND_SUBMIT, 3'd0, 3'd0);
    send_op(KIND_TAKE_READ, 3'd0, 3'd0);
    send_op(KIND_RELEASE, 3'd0, 3'd0);
    send_op(KIND_RECYCLE, 3'd1, 3'd0);
    send_op(KIND_RECYCLE, 3'd1, 3'd0);
    send_op(KIND_SUBMIT, 3'd2, 3'd0);
    send_op(KIND_RECYCLE, 3'd2, 3'd0);
    send_op(KIND_LINK, 3'd3, 3'd4);
    send_op(KIND_LINK, 3'd3, 3'd5);
    send_op(KIND_RECYCLE, 3'd3, 3'd0);
    // looped chain 6 -> 7 -> 6
    send_op(KIND_LINK, 3'd6, 3'd7);
    send_op(KIND_LINK, 3'd7, 3'd6);
    send_op(KIND_RECYCLE, 3'd6, 3'd0);
    send_op(KIND_LINK, 3'd6, 3'd1);
    send_op(KindSpareA, 3'd7, 3'd7);
    send_op(KindSpareB, 3'd5, 3'd2);
    drain_ops();

    // Small pool: out-of-pool frames, chain with a free member, notify.
    write_reg(REG_POOL_SIZE, 4'd3);
    write_reg(REG_NOTIFY_EN, 4'b1111);
    send_op(KIND_TAKE_WRITE, 3'd0, 3'd0);
    send_op(KIND_SUBMIT, 3'd0, 3'd0);
    send_op(KIND_SUBMIT, 3'd7, 3'd0);
    send_op(KIND_LINK, 3'd0, 3'd7);
    send_op(KIND_TAKE_WRITE, 3'd0, 3'd0);
    send_op(KIND_LINK, 3'd1, 3'd2);
    send_op(KIND_RECYCLE, 3'd1, 3'd0);
    send_op(KIND_RECYCLE, 3'd7, 3'd0);
    drain_ops();

    for (int p = 0; p < NumPhases; p++) begin
      write_reg(REG_POOL_SIZE, phase_sizes[p]);
      write_reg(REG_NOTIFY_EN, {3'($urandom_range(0, 7)), p[0]});
      no_gap   = ($urandom_range(0, 3) == 0);
      no_stall = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < ItemsPerPhase; i++) begin
        pick_op(k, fi, oi);
        send_op(k, fi, oi);
      end
      drain_ops();
      no_gap   = 1'b0;
      no_stall = 1'b0;
    end

    drain_ops();
    if (err_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/fbpm_pkg.sv
rtl/frame_buffer_pool_manager_top.sv
tb/fbpm_pool_checker.sv
tb/frame_buffer_pool_manager_top_tb.sv
